FILE: hdl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants and types for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

	localparam int MAX_KEPT    = 64;
	localparam int SLOT_W      = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W       = $clog2(MAX_KEPT + 1);
	localparam int COORD_W     = 16;
	localparam int EXT_W       = 15;
	localparam int AREA_W      = 2 * EXT_W;
	localparam int UNI_W       = AREA_W + 1;
	localparam int THR_W       = 16;
	localparam int PROD_W      = THR_W + UNI_W;
	localparam int KEPT_SLOT_W = 6;

	localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

	typedef struct packed {
		logic signed [COORD_W-1:0] left;
		logic signed [COORD_W-1:0] top;
		logic [EXT_W-1:0]          width;
		logic [EXT_W-1:0]          height;
		logic [AREA_W-1:0]         area;
	} gbs_entry_t;

	typedef struct packed {
		logic              load;
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic              emit;
		logic              store;
		logic [CNT_W-1:0]  n;
	} gbs_cmd_t;

	typedef struct packed {
		logic busy;
		logic suppress;
		logic out_free;
	} gbs_status_t;

endpackage

FILE: hdl/gbs_if.sv
// ----------------------------------------------------------------------------
// gbs_if
// Channel interfaces: box input, result output and threshold write.
// ----------------------------------------------------------------------------
interface gbs_box_if;
	logic                                valid;
	logic                                ready;
	logic                                first_of_set;
	logic signed [gbs_pkg::COORD_W-1:0]  box_left;
	logic signed [gbs_pkg::COORD_W-1:0]  box_top;
	logic [gbs_pkg::EXT_W-1:0]           box_width;
	logic [gbs_pkg::EXT_W-1:0]           box_height;

	modport source (output valid, first_of_set, box_left, box_top, box_width, box_height,
		input ready);
	modport sink (input valid, first_of_set, box_left, box_top, box_width, box_height,
		output ready);
endinterface

interface gbs_result_if;
	logic                              valid;
	logic                              ready;
	logic                              keep;
	logic [gbs_pkg::KEPT_SLOT_W-1:0]   kept_slot;
	logic                              store_full;

	modport source (output valid, keep, kept_slot, store_full, input ready);
	modport sink (input valid, keep, kept_slot, store_full, output ready);
endinterface

interface gbs_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [gbs_pkg::THR_W-1:0]     data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: hdl/gbs_ctrl.sv
// ----------------------------------------------------------------------------
// gbs_ctrl
// Sequencer: accepts a box, scans the kept store one entry per cycle,
// waits for the compare pipeline to drain, then issues the result.
// ----------------------------------------------------------------------------
module gbs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_first,
	output logic                  in_ready,
	input  gbs_pkg::gbs_status_t  status,
	output gbs_pkg::gbs_cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [gbs_pkg::CNT_W-1:0]     count_q;
	logic [gbs_pkg::CNT_W-1:0]     n_q;
	logic [gbs_pkg::SLOT_W-1:0]    idx_q;
	logic                          accept;
	logic                          store;
	logic [gbs_pkg::CNT_W-1:0]     n_start;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign n_start  = in_first ? '0 : count_q;
	assign store    = !status.suppress && (n_q < gbs_pkg::CNT_W'(gbs_pkg::MAX_KEPT));

	always_comb begin
		cmd         = '0;
		cmd.load    = accept;
		cmd.rd_en   = (state_q == ST_SCAN);
		cmd.rd_addr = idx_q;
		cmd.emit    = (state_q == ST_DONE) && status.out_free;
		cmd.store   = cmd.emit && store;
		cmd.n       = n_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			n_q     <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q     <= n_start;
						idx_q   <= '0;
						state_q <= (n_start == '0) ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (gbs_pkg::CNT_W'(idx_q) == n_q - gbs_pkg::CNT_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!status.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (status.out_free) begin
						count_q <= store ? n_q + 1'b1 : n_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/gbs_datapath.sv
// ----------------------------------------------------------------------------
// gbs_datapath
// Kept-box store, six-stage overlap/union compare pipeline, suppression
// flag, threshold register and result register.
// ----------------------------------------------------------------------------
module gbs_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gbs_pkg::gbs_cmd_t                   cmd,
	output gbs_pkg::gbs_status_t                status,
	input  logic                                cfg_we,
	input  logic [gbs_pkg::THR_W-1:0]           cfg_data,
	input  logic signed [gbs_pkg::COORD_W-1:0]  box_left,
	input  logic signed [gbs_pkg::COORD_W-1:0]  box_top,
	input  logic [gbs_pkg::EXT_W-1:0]           box_width,
	input  logic [gbs_pkg::EXT_W-1:0]           box_height,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                keep,
	output logic [gbs_pkg::KEPT_SLOT_W-1:0]     kept_slot,
	output logic                                store_full
);

	localparam int CW = gbs_pkg::COORD_W;
	localparam int RW = gbs_pkg::COORD_W + 1;
	localparam int DW = gbs_pkg::COORD_W + 2;

	gbs_pkg::gbs_entry_t          kept_mem [gbs_pkg::MAX_KEPT];

	logic [gbs_pkg::THR_W-1:0]    iou_threshold_q;
	logic signed [CW-1:0]         cur_left_q, cur_top_q;
	logic signed [RW-1:0]         cur_right_q, cur_bottom_q;
	logic [gbs_pkg::EXT_W-1:0]    cur_width_q, cur_height_q;
	logic [gbs_pkg::AREA_W-1:0]   cur_area_q;
	logic                         suppress_q;
	logic                         out_valid_q, keep_q, store_full_q;
	logic [gbs_pkg::KEPT_SLOT_W-1:0] kept_slot_q;

	gbs_pkg::gbs_entry_t          ent_s1;
	logic                         valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	logic signed [CW-1:0]         l_s2, t_s2;
	logic signed [RW-1:0]         r_s2, b_s2;
	logic [gbs_pkg::AREA_W-1:0]   karea_s2, karea_s3, karea_s4;
	logic signed [DW-1:0]         w_s3, h_s3;
	logic [gbs_pkg::AREA_W-1:0]   inter_s4, inter_s5, inter_s6;
	logic [gbs_pkg::UNI_W-1:0]    uni_s5;
	logic [gbs_pkg::PROD_W-1:0]   prod_s6;
	logic                         uni_nz_s6;

	logic signed [RW-1:0]         k_right, k_bottom;
	logic                         pos_w, pos_h;
	logic [gbs_pkg::PROD_W-1:0]   lhs;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iou_threshold_q <= gbs_pkg::THR_RESET;
		end else if (cfg_we) begin
			iou_threshold_q <= cfg_data;
		end
	end

	// current box
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_left_q   <= box_left;
			cur_top_q    <= box_top;
			cur_width_q  <= box_width;
			cur_height_q <= box_height;
			cur_right_q  <= RW'(box_left) + $signed({2'b00, box_width});
			cur_bottom_q <= RW'(box_top) + $signed({2'b00, box_height});
			cur_area_q   <= box_width * box_height;
		end
	end

	// kept store
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			kept_mem[cmd.n[gbs_pkg::SLOT_W-1:0]] <= '{left: cur_left_q, top: cur_top_q,
				width: cur_width_q, height: cur_height_q, area: cur_area_q};
		end
		if (cmd.rd_en) begin
			ent_s1 <= kept_mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	assign k_right  = RW'(ent_s1.left) + $signed({2'b00, ent_s1.width});
	assign k_bottom = RW'(ent_s1.top) + $signed({2'b00, ent_s1.height});
	assign pos_w    = !w_s3[DW-1] && (w_s3 != '0);
	assign pos_h    = !h_s3[DW-1] && (h_s3 != '0);
	assign lhs      = gbs_pkg::PROD_W'({inter_s6, 16'h0000});

	always_ff @(posedge clk) begin
		// s2: overlap edges
		l_s2     <= (cur_left_q > ent_s1.left) ? cur_left_q : ent_s1.left;
		t_s2     <= (cur_top_q > ent_s1.top) ? cur_top_q : ent_s1.top;
		r_s2     <= (cur_right_q < k_right) ? cur_right_q : k_right;
		b_s2     <= (cur_bottom_q < k_bottom) ? cur_bottom_q : k_bottom;
		karea_s2 <= ent_s1.area;
		// s3: overlap extents
		w_s3     <= DW'(r_s2) - DW'(l_s2);
		h_s3     <= DW'(b_s2) - DW'(t_s2);
		karea_s3 <= karea_s2;
		// s4: intersection
		inter_s4 <= (pos_w && pos_h) ? w_s3[gbs_pkg::EXT_W-1:0] * h_s3[gbs_pkg::EXT_W-1:0]
			: '0;
		karea_s4 <= karea_s3;
		// s5: union
		uni_s5   <= gbs_pkg::UNI_W'(cur_area_q) + gbs_pkg::UNI_W'(karea_s4)
			- gbs_pkg::UNI_W'(inter_s4);
		inter_s5 <= inter_s4;
		// s6: threshold times union
		prod_s6   <= gbs_pkg::PROD_W'(iou_threshold_q) * gbs_pkg::PROD_W'(uni_s5);
		uni_nz_s6 <= (uni_s5 != '0);
		inter_s6  <= inter_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			suppress_q <= 1'b0;
		end else if (cmd.load) begin
			suppress_q <= 1'b0;
		end else if (valid_s6 && uni_nz_s6 && (lhs > prod_s6)) begin
			suppress_q <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			keep_q       <= !suppress_q;
			store_full_q <= !suppress_q && !cmd.store;
			kept_slot_q  <= cmd.store ? gbs_pkg::KEPT_SLOT_W'(cmd.n) : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign keep       = keep_q;
	assign kept_slot  = kept_slot_q;
	assign store_full = store_full_q;

	assign status.busy     = valid_s1 | valid_s2 | valid_s3 | valid_s4 | valid_s5 | valid_s6;
	assign status.suppress = suppress_q;
	assign status.out_free = !out_valid_q || out_ready;

endmodule

FILE: hdl/greedy_box_suppression.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy non-maximum suppression over score-sorted boxes.
//
// Channels: boxes (in) carries one box per transfer, first_of_set empties
// the kept list first. results (out) carries keep, kept_slot, store_full,
// one transfer per box. cfg writes iou_threshold (Q0.16); cfg is always
// ready; it must be written only while the block is idle, which the block
// itself does not enforce. Each box is compared with every kept box of
// the set, one per cycle, through a six-stage overlap/union/threshold
// pipeline fed by the kept store's read port. A box's result follows the
// scan of the kept boxes ahead of it (skipped if none) and the pipeline
// drain; the next box is taken the cycle after its result is registered.
// The result register frees the core: the next box is accepted while a
// result still waits. If the receiver stalls with a result pending, the
// following box finishes its scan and waits until the register frees.
// Reset clears the kept count and all handshakes; the threshold resets to 0.45.
// ----------------------------------------------------------------------------
module greedy_box_suppression (
	input  logic           clk,
	input  logic           arst_n,
	gbs_box_if.sink        boxes,
	gbs_result_if.source   results,
	gbs_cfg_if.sink        cfg
);

	gbs_pkg::gbs_cmd_t     cmd;
	gbs_pkg::gbs_status_t  status;

	assign cfg.ready = 1'b1;

	gbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (boxes.valid),
		.in_first (boxes.first_of_set),
		.in_ready (boxes.ready),
		.status   (status),
		.cmd      (cmd)
	);

	gbs_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_we     (cfg.valid),
		.cfg_data   (cfg.data),
		.box_left   (boxes.box_left),
		.box_top    (boxes.box_top),
		.box_width  (boxes.box_width),
		.box_height (boxes.box_height),
		.out_valid  (results.valid),
		.out_ready  (results.ready),
		.keep       (results.keep),
		.kept_slot  (results.kept_slot),
		.store_full (results.store_full)
	);

endmodule

FILE: hdl/gbs_checker.sv
// ----------------------------------------------------------------------------
// gbs_checker
// Port-level checks for greedy_box_suppression, bound to the top level.
// ----------------------------------------------------------------------------
module gbs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic                               keep,
	input logic [gbs_pkg::KEPT_SLOT_W-1:0]    kept_slot,
	input logic                               store_full
);

	// one box in flight: no transfer right after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("box accepted while previous box in flight");

	a_drop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !keep |-> (kept_slot == '0) && !store_full)
		else $error("dropped box reports slot or full");

	a_full_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && store_full |-> keep && (kept_slot == '0))
		else $error("full flag on non-kept box or nonzero slot");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(keep) && $stable(kept_slot)
			&& $stable(store_full))
		else $error("stalled result changed");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (boxes.valid),
	.in_ready   (boxes.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.keep       (results.keep),
	.kept_slot  (results.kept_slot),
	.store_full (results.store_full)
);

FILE: dv/greedy_box_suppression_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression_tb
// Self-checking bench for the greedy box suppression block. Boxes are sent in
// sets: first a short directed list, then a filled store and both threshold
// extremes. A long result stall follows, and last come random clustered sets
// with varied thresholds. A predictor keeps its own kept list and threshold
// and queues the expected keep/slot/full verdict per accepted box. Each
// result transfer is checked against the oldest verdict.
// ----------------------------------------------------------------------------
module greedy_box_suppression_tb;

	localparam int HOLD_CYCLES    = 500;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		logic                               first;
		logic signed [gbs_pkg::COORD_W-1:0] left;
		logic signed [gbs_pkg::COORD_W-1:0] top;
		logic [gbs_pkg::EXT_W-1:0]          width;
		logic [gbs_pkg::EXT_W-1:0]          height;
	} box_item_t;

	typedef struct {
		logic                            keep;
		logic [gbs_pkg::KEPT_SLOT_W-1:0] slot;
		logic                            full;
	} verdict_t;

	logic clk;
	logic arst_n;

	gbs_box_if    boxes();
	gbs_result_if results();
	gbs_cfg_if    cfg();

	greedy_box_suppression i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.boxes(boxes),
		.results(results),
		.cfg(cfg)
	);

	// predictor state
	box_item_t       kept_box [gbs_pkg::MAX_KEPT];
	longint unsigned kept_area [gbs_pkg::MAX_KEPT];
	int              kept_count;
	longint unsigned iou_thr;
	verdict_t        verdict_q [$];

	// stimulus state
	box_item_t set_hist [$];
	bit        idle_en;
	int        hold_reqs;
	int        hold_done;
	int        hold_left;
	int        stall_left;
	int        quiet_cycles;
	int        errors;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int imax(int a, int b);
		return (a > b) ? a : b;
	endfunction

	function automatic int imin(int a, int b);
		return (a < b) ? a : b;
	endfunction

	task automatic predict_verdict(input box_item_t b);
		longint unsigned area;
		longint unsigned inter;
		longint unsigned uni;
		int x0, y0, x1, y1, ow, oh;
		bit drop;
		verdict_t v;
		if (b.first) begin
			kept_count = 0;
		end
		area = longint'(b.width) * longint'(b.height);
		drop = 1'b0;
		for (int i = 0; i < kept_count && !drop; i++) begin
			x0 = imax(int'(b.left), int'(kept_box[i].left));
			y0 = imax(int'(b.top), int'(kept_box[i].top));
			x1 = imin(int'(b.left) + int'(b.width),
				int'(kept_box[i].left) + int'(kept_box[i].width));
			y1 = imin(int'(b.top) + int'(b.height),
				int'(kept_box[i].top) + int'(kept_box[i].height));
			ow = x1 - x0;
			oh = y1 - y0;
			inter = (ow > 0 && oh > 0) ? longint'(ow) * longint'(oh) : 64'd0;
			uni = area + kept_area[i] - inter;
			if (uni != 0 && (inter << 16) > iou_thr * uni) begin
				drop = 1'b1;
			end
		end
		if (drop) begin
			v = '{1'b0, '0, 1'b0};
		end else if (kept_count >= gbs_pkg::MAX_KEPT) begin
			v = '{1'b1, '0, 1'b1};
		end else begin
			kept_box[kept_count] = b;
			kept_area[kept_count] = area & 64'h3FFF_FFFF;
			v.keep = 1'b1;
			v.slot = gbs_pkg::KEPT_SLOT_W'(kept_count);
			v.full = 1'b0;
			kept_count++;
		end
		verdict_q = {verdict_q, v};
	endtask

	task automatic send_box(input box_item_t b);
		int gap;
		gap = (idle_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			boxes.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		boxes.valid        <= 1'b1;
		boxes.first_of_set <= b.first;
		boxes.box_left     <= b.left;
		boxes.box_top      <= b.top;
		boxes.box_width    <= b.width;
		boxes.box_height   <= b.height;
		do @(posedge clk); while (boxes.ready !== 1'b1);
		predict_verdict(b);
		set_hist = {set_hist, b};
	endtask

	task automatic wait_for_results();
		boxes.valid <= 1'b0;
		do @(posedge clk); while (verdict_q.size() != 0);
	endtask

	task automatic write_threshold(input logic [gbs_pkg::THR_W-1:0] thr);
		wait_for_results();
		cfg.valid <= 1'b1;
		cfg.data  <= thr;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		iou_thr = thr;
	endtask

	// box near an earlier one of the set, in a local region, anywhere, or degenerate
	function automatic box_item_t cluster_box();
		box_item_t b;
		box_item_t p;
		int sel, dx, dy, w, h;
		sel = $urandom_range(0, 19);
		if (set_hist.size() != 0 && sel < 10) begin
			p = set_hist[$urandom_range(0, set_hist.size() - 1)];
			dx = int'(p.width) / 3 + 1;
			dy = int'(p.height) / 3 + 1;
			b.left = gbs_pkg::COORD_W'(int'(p.left) + int'($urandom_range(0, 2 * dx)) - dx);
			b.top  = gbs_pkg::COORD_W'(int'(p.top) + int'($urandom_range(0, 2 * dy)) - dy);
			w = imin(imax(int'(p.width) + int'($urandom_range(0, 2 * dx)) - dx, 16), 32767);
			h = imin(imax(int'(p.height) + int'($urandom_range(0, 2 * dy)) - dy, 16), 32767);
			b.width  = gbs_pkg::EXT_W'(w);
			b.height = gbs_pkg::EXT_W'(h);
		end else if (sel < 16) begin
			b.left   = gbs_pkg::COORD_W'(int'($urandom_range(0, 8192)) - 4096);
			b.top    = gbs_pkg::COORD_W'(int'($urandom_range(0, 8192)) - 4096);
			b.width  = gbs_pkg::EXT_W'($urandom_range(16, 4096));
			b.height = gbs_pkg::EXT_W'($urandom_range(16, 4096));
		end else if (sel < 18) begin
			b.left   = gbs_pkg::COORD_W'($urandom);
			b.top    = gbs_pkg::COORD_W'($urandom);
			b.width  = gbs_pkg::EXT_W'($urandom);
			b.height = gbs_pkg::EXT_W'($urandom);
		end else begin
			b.left   = gbs_pkg::COORD_W'(int'($urandom_range(0, 8192)) - 4096);
			b.top    = gbs_pkg::COORD_W'(int'($urandom_range(0, 8192)) - 4096);
			b.width  = gbs_pkg::EXT_W'($urandom_range(0, 15));
			b.height = gbs_pkg::EXT_W'($urandom_range(0, 4096));
			if ($urandom_range(0, 1) == 1) begin
				b.width  = gbs_pkg::EXT_W'($urandom_range(0, 4096));
				b.height = gbs_pkg::EXT_W'($urandom_range(0, 15));
			end
		end
		b.first = 1'b0;
		return b;
	endfunction

	// disjoint boxes on a 10 x 8 grid, with the odd repeat of an earlier one
	function automatic box_item_t grid_box(input int k);
		box_item_t b;
		if (set_hist.size() != 0 && $urandom_range(0, 7) == 0) begin
			b = set_hist[$urandom_range(0, set_hist.size() - 1)];
		end else begin
			b.left   = gbs_pkg::COORD_W'(-4096 + (k % 10) * 512 + int'($urandom_range(0, 96)));
			b.top    = gbs_pkg::COORD_W'(-4096 + (k / 10) * 512 + int'($urandom_range(0, 96)));
			b.width  = gbs_pkg::EXT_W'($urandom_range(16, 400));
			b.height = gbs_pkg::EXT_W'($urandom_range(16, 400));
		end
		b.first = 1'b0;
		return b;
	endfunction

	task automatic run_random_sets(input int n_items);
		int sent, set_len;
		bit sparse;
		box_item_t b;
		sent = 0;
		while (sent < n_items) begin
			sparse = ($urandom_range(0, 19) == 0);
			set_len = sparse ? $urandom_range(70, 80) : $urandom_range(1, 40);
			set_hist.delete();
			for (int k = 0; k < set_len; k++) begin
				b = sparse ? grid_box(k) : cluster_box();
				b.first = (k == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 63) == 0);
				send_box(b);
				sent++;
			end
		end
	endtask

	task automatic test_directed();
		send_box(box_item_t'{1'b1, 0, 0, 160, 160});
		send_box(box_item_t'{1'b0, 0, 0, 160, 160});
		send_box(box_item_t'{1'b0, 4000, 4000, 160, 160});
		send_box(box_item_t'{1'b0, 0, 0, 0, 160});
		send_box(box_item_t'{1'b0, 0, 0, 0, 0});
		send_box(box_item_t'{1'b0, 0, 0, 160, 0});
		// edge-touching boxes, then just above and just below 0.45
		send_box(box_item_t'{1'b1, 0, 0, 160, 160});
		send_box(box_item_t'{1'b0, 160, 0, 160, 160});
		send_box(box_item_t'{1'b0, 0, 160, 160, 160});
		send_box(box_item_t'{1'b0, 60, 0, 160, 160});
		send_box(box_item_t'{1'b0, 61, 0, 160, 160});
		send_box(box_item_t'{1'b0, -500, -500, 16, 16});
		send_box(box_item_t'{1'b1, -32768, -32768, 32767, 32767});
		send_box(box_item_t'{1'b0, 32767, 32767, 32767, 32767});
		send_box(box_item_t'{1'b0, -32768, 32767, 16, 16});
		send_box(box_item_t'{1'b0, -32760, -32768, 32767, 32767});
		send_box(box_item_t'{1'b0, 21845, -21846, 10922, 21845});
		send_box(box_item_t'{1'b0, -21846, 21845, 21845, 10922});
		send_box(box_item_t'{1'b1, 100, 100, 32767, 16});
		send_box(box_item_t'{1'b0, 100, 100, 16, 32767});
	endtask

	task automatic test_full_store();
		box_item_t b;
		set_hist.delete();
		for (int k = 0; k < 80; k++) begin
			b = grid_box(k);
			b.first = (k == 0);
			send_box(b);
		end
	endtask

	task automatic test_threshold_extremes();
		write_threshold('0);
		run_random_sets(60);
		write_threshold('1);
		run_random_sets(60);
	endtask

	// receiver stalls long while boxes keep coming, then the sender drains
	task automatic test_backpressure();
		box_item_t b;
		wait_for_results();
		hold_reqs <= hold_reqs + 1;
		set_hist.delete();
		for (int k = 0; k < 12; k++) begin
			b = cluster_box();
			b.first = (k == 0);
			send_box(b);
		end
		wait_for_results();
	endtask

	task automatic test_random();
		write_threshold(gbs_pkg::THR_W'($urandom));
		run_random_sets(400);
		write_threshold(gbs_pkg::THR_W'($urandom_range(20000, 40000)));
		run_random_sets(400);
		write_threshold(gbs_pkg::THR_W'($urandom_range(40000, 65535)));
		run_random_sets(400);
		write_threshold(gbs_pkg::THR_W'($urandom));
		idle_en = 1'b0;
		run_random_sets(330);
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			results.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_reqs) begin
			hold_done <= hold_reqs;
			hold_left <= HOLD_CYCLES - 1;
			results.ready <= 1'b0;
		end else if (stall_left > 0) begin
			results.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			results.ready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			results.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && results.valid === 1'b1 && results.ready === 1'b1) begin
			if (verdict_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result: keep=%0b slot=%0d full=%0b",
						results.keep, results.kept_slot, results.store_full);
			end else begin
				want = verdict_q.pop_front();
				if (results.keep !== want.keep || results.kept_slot !== want.slot ||
						results.store_full !== want.full) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("mismatch: exp keep=%0b slot=%0d full=%0b got %0b %0d %0b",
							want.keep, want.slot, want.full,
							results.keep, results.kept_slot, results.store_full);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (boxes.valid && boxes.ready) || (results.valid && results.ready) ||
				(cfg.valid && cfg.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n             = 1'b0;
		boxes.valid        = 1'b0;
		boxes.first_of_set = 1'b0;
		boxes.box_left     = '0;
		boxes.box_top      = '0;
		boxes.box_width    = '0;
		boxes.box_height   = '0;
		results.ready      = 1'b0;
		cfg.valid          = 1'b0;
		cfg.data           = '0;
		idle_en            = 1'b1;
		kept_count         = 0;
		iou_thr            = gbs_pkg::THR_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_store();
		test_threshold_extremes();
		test_backpressure();
		test_random();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && verdict_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
